// File: src/pmd_pkg.sv
// Package for the PS/2 mouse packet decoder: widths, register indexes and
// the packet word passed from the front end to the cursor back end. No dependencies.
`timescale 1ns / 1ps

package pmd_pkg;

  // Cursor coordinate width (8 .. 16)
  localparam int COORD_BITS = 12;

  // Screen size register width
  localparam int SIZE_W = 13;

  // Width that holds both a size value and the coordinate span
  localparam int SIZE_CMP_W = (COORD_BITS + 1 > SIZE_W) ? COORD_BITS + 1 : SIZE_W;

  // Signed width of position plus or minus a nine-bit delta
  localparam int SUM_W = COORD_BITS + 2;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_DECODE_ENABLE = 2'd0,
    REG_SCREEN_WIDTH  = 2'd1,
    REG_SCREEN_HEIGHT = 2'd2
  } pmd_reg_e;

  // Reset values of the configuration registers
  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(768);

  // Header bit positions
  localparam int HDR_LEFT   = 0;
  localparam int HDR_RIGHT  = 1;
  localparam int HDR_MIDDLE = 2;
  localparam int HDR_SYNC   = 3;
  localparam int HDR_XSIGN  = 4;
  localparam int HDR_YSIGN  = 5;

  // Byte position within a packet
  typedef enum logic [1:0] {
    POS_HEADER = 2'd0,
    POS_XDELTA = 2'd1,
    POS_YDELTA = 2'd2
  } pmd_pos_e;

  // One complete packet
  typedef struct packed {
    logic [7:0] header;
    logic [7:0] x_delta;
    logic [7:0] y_delta;
  } pmd_packet_t;

endpackage

// File: src/pmd_front.sv
// Front end: takes raw mouse bytes, tracks the packet position and hands
// complete packets to the queue. Depends on pmd_pkg.
`timescale 1ns / 1ps

module pmd_front import pmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        decode_enable_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        push_o,
  output pmd_packet_t push_data_o,
  input  logic        queue_full_i
);

  pmd_pos_e   pos_q, pos_d;
  logic [7:0] header_q, header_d;
  logic [7:0] x_delta_q, x_delta_d;
  logic       accept;

  // Stall only while the queue is full
  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Packet position sequencer
  always_comb begin
    pos_d     = pos_q;
    header_d  = header_q;
    x_delta_d = x_delta_q;
    push_o    = 1'b0;
    if (accept && decode_enable_i) begin
      unique case (pos_q)
        POS_HEADER: begin
          // a header without the sync bit is dropped
          if (data_byte_i[HDR_SYNC]) begin
            header_d = data_byte_i;
            pos_d    = POS_XDELTA;
          end
        end
        POS_XDELTA: begin
          x_delta_d = data_byte_i;
          pos_d     = POS_YDELTA;
        end
        POS_YDELTA: begin
          push_o = 1'b1;
          pos_d  = POS_HEADER;
        end
        default: pos_d = POS_HEADER;
      endcase
    end
  end

  assign push_data_o = '{header: header_q, x_delta: x_delta_q, y_delta: data_byte_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= POS_HEADER;
      header_q  <= '0;
      x_delta_q <= '0;
    end else begin
      pos_q     <= pos_d;
      header_q  <= header_d;
      x_delta_q <= x_delta_d;
    end
  end

endmodule

// File: src/pmd_queue.sv
// Two-entry packet queue between the front end and the cursor back end.
// Depends on pmd_pkg.
`timescale 1ns / 1ps

module pmd_queue import pmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  pmd_packet_t push_data_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        not_empty_o,
  output pmd_packet_t pop_data_o
);

  pmd_packet_t entries_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  logic        do_push, do_pop;

  assign full_o      = (count_q == 2'd2);
  assign not_empty_o = (count_q != 2'd0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign pop_data_o  = entries_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// File: src/pmd_back.sv
// Back end: applies packet deltas to the cursor, clamps to the screen and
// holds the result word in the output register. Depends on pmd_pkg.
`timescale 1ns / 1ps

module pmd_back import pmd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [SIZE_W-1:0]     screen_width_i,
  input  logic [SIZE_W-1:0]     screen_height_i,
  input  logic                  pkt_valid_i,
  input  pmd_packet_t           pkt_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS-1:0] cursor_x_o,
  output logic [COORD_BITS-1:0] cursor_y_o,
  output logic                  button_left_o,
  output logic                  button_right_o,
  output logic                  button_middle_o
);

  localparam logic [SIZE_CMP_W-1:0] Span = SIZE_CMP_W'(1) << COORD_BITS;

  logic [COORD_BITS-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic                  out_valid_q;
  logic [COORD_BITS-1:0] out_x_q, out_y_q;
  logic [2:0]            buttons_q;
  logic signed [8:0]     dx, dy;
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic [COORD_BITS-1:0] max_x, max_y;

  // Largest legal coordinate for a size value
  function automatic logic [COORD_BITS-1:0] axis_max(input logic [SIZE_W-1:0] size);
    logic [SIZE_CMP_W-1:0] s;
    logic [SIZE_CMP_W-1:0] m;
    s = SIZE_CMP_W'(size);
    if (s == '0) begin
      m = '0;
    end else if (s > Span) begin
      m = Span - SIZE_CMP_W'(1);
    end else begin
      m = s - SIZE_CMP_W'(1);
    end
    return m[COORD_BITS-1:0];
  endfunction

  // Clamp a signed sum into 0 .. max
  function automatic logic [COORD_BITS-1:0] clamp(input logic signed [SUM_W-1:0] v,
                                                  input logic [COORD_BITS-1:0] mx);
    logic [COORD_BITS:0] mag;
    mag = v[SUM_W-2:0];
    if (v[SUM_W-1]) begin
      return '0;
    end else if (mag > {1'b0, mx}) begin
      return mx;
    end else begin
      return mag[COORD_BITS-1:0];
    end
  endfunction

  assign pop_o = pkt_valid_i && (!out_valid_q || out_ready_i);

  // Nine-bit deltas: header sign bit on top of the raw byte
  assign dx = {pkt_i.header[HDR_XSIGN], pkt_i.x_delta};
  assign dy = {pkt_i.header[HDR_YSIGN], pkt_i.y_delta};

  assign max_x = axis_max(screen_width_i);
  assign max_y = axis_max(screen_height_i);

  // X adds, Y subtracts (screen Y grows downward)
  assign sum_x = $signed({2'b00, pos_x_q}) + SUM_W'(dx);
  assign sum_y = $signed({2'b00, pos_y_q}) - SUM_W'(dy);

  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    if (pop_o) begin
      pos_x_d = clamp(sum_x, max_x);
      pos_y_d = clamp(sum_y, max_y);
    end
  end

  // Cursor state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output word
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_x_q   <= pos_x_d;
      out_y_q   <= pos_y_d;
      buttons_q <= {pkt_i.header[HDR_MIDDLE], pkt_i.header[HDR_RIGHT],
                    pkt_i.header[HDR_LEFT]};
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cursor_x_o      = out_x_q;
  assign cursor_y_o      = out_y_q;
  assign button_left_o   = buttons_q[0];
  assign button_right_o  = buttons_q[1];
  assign button_middle_o = buttons_q[2];

endmodule

// File: src/ps2_mouse_packet_decoder_top.sv
// Top level of the PS/2 mouse packet decoder: configuration registers,
// front end, packet queue and cursor back end. Depends on pmd_pkg and the pmd_* modules.
//
//   channel  direction  handshake                signals
//   input    in         in_valid_i / in_ready_o  data_byte_i
//   result   out        out_valid_o / out_ready_i cursor_x_o, cursor_y_o, button_*_o
//   config   in         cfg_we_i                 cfg_index_i, cfg_data_i
//
// One byte per cycle is taken while in_ready_o is high; the third byte of a packet
// passes through the packet queue into the output register as a result word.
// in_ready_o drops only while the two-entry packet queue is full, which takes a
// stalled result side plus two further packets.
// Reset is asynchronous, active low; it clears packet position, cursor and queue.
`timescale 1ns / 1ps

module ps2_mouse_packet_decoder_top import pmd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [SIZE_W-1:0]     cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS-1:0] cursor_x_o,
  output logic [COORD_BITS-1:0] cursor_y_o,
  output logic                  button_left_o,
  output logic                  button_right_o,
  output logic                  button_middle_o
);

  logic              enable_q;
  logic [SIZE_W-1:0] width_q, height_q;
  logic              push, queue_full, pop, queue_not_empty;
  pmd_packet_t       push_data, pop_data;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_DECODE_ENABLE: enable_q <= cfg_data_i[0];
        REG_SCREEN_WIDTH:  width_q  <= cfg_data_i;
        REG_SCREEN_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pmd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .decode_enable_i (enable_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .push_o          (push),
    .push_data_o     (push_data),
    .queue_full_i    (queue_full)
  );

  pmd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (queue_full),
    .pop_i       (pop),
    .not_empty_o (queue_not_empty),
    .pop_data_o  (pop_data)
  );

  pmd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .screen_width_i  (width_q),
    .screen_height_i (height_q),
    .pkt_valid_i     (queue_not_empty),
    .pkt_i           (pop_data),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cursor_x_o      (cursor_x_o),
    .cursor_y_o      (cursor_y_o),
    .button_left_o   (button_left_o),
    .button_right_o  (button_right_o),
    .button_middle_o (button_middle_o)
  );

endmodule

// File: tb/tb_ps2_mouse_packet_decoder_top.sv
// Self-checking testbench for ps2_mouse_packet_decoder_top: drives mouse bytes,
// tracks packet decode and cursor clamping in its own tracker, and checks every result word.
// Depends on pmd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_decoder_top;
  import pmd_pkg::*;

  // One result word as the block should emit it
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  left;
    logic                  right;
    logic                  middle;
  } cursor_word_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [1:0]            cfg_index_i;
  logic [SIZE_W-1:0]     cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [7:0]            data_byte_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [COORD_BITS-1:0] cursor_x_o;
  logic [COORD_BITS-1:0] cursor_y_o;
  logic                  button_left_o;
  logic                  button_right_o;
  logic                  button_middle_o;

  // Tracker copy of the configuration
  logic              dec_en;
  logic [SIZE_W-1:0] scr_w;
  logic [SIZE_W-1:0] scr_h;

  // Tracker copy of the packet and cursor state
  pmd_pos_e              pkt_pos;
  logic [7:0]            pkt_hdr;
  logic [7:0]            pkt_xd;
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;

  cursor_word_t expected_cursors[$];

  int err_cnt;
  bit tx_gaps;
  bit rx_stalls;
  int rx_hold_cycles;

  ps2_mouse_packet_decoder_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cursor_x_o      (cursor_x_o),
    .cursor_y_o      (cursor_y_o),
    .button_left_o   (button_left_o),
    .button_right_o  (button_right_o),
    .button_middle_o (button_middle_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Clamp one axis; size 0 acts as 1, sizes past the coordinate span act as the span
  function automatic logic [COORD_BITS-1:0] clamp_coord(int v, logic [SIZE_W-1:0] size);
    int lim;
    lim = int'(size);
    if (lim < 1) lim = 1;
    if (lim > (1 << COORD_BITS)) lim = 1 << COORD_BITS;
    if (v < 0) return '0;
    if (v >= lim) return COORD_BITS'(lim - 1);
    return COORD_BITS'(v);
  endfunction

  // Advance the tracker by one accepted byte; a finished packet queues a cursor word
  function automatic void decode_mouse_byte(logic [7:0] b);
    int           dx;
    int           dy;
    cursor_word_t w;
    if (!dec_en) return;
    case (pkt_pos)
      POS_HEADER: begin
        // header without sync is dropped, position stays at header
        if (b[HDR_SYNC]) begin
          pkt_hdr = b;
          pkt_pos = POS_XDELTA;
        end
      end
      POS_XDELTA: begin
        pkt_xd  = b;
        pkt_pos = POS_YDELTA;
      end
      default: begin
        pkt_pos = POS_HEADER;
        dx = int'(pkt_xd) - (pkt_hdr[HDR_XSIGN] ? 256 : 0);
        dy = int'(b) - (pkt_hdr[HDR_YSIGN] ? 256 : 0);
        // screen y grows downward, so the mouse y delta is subtracted
        cur_x = clamp_coord(int'(cur_x) + dx, scr_w);
        cur_y = clamp_coord(int'(cur_y) - dy, scr_h);
        w.x      = cur_x;
        w.y      = cur_y;
        w.left   = pkt_hdr[HDR_LEFT];
        w.right  = pkt_hdr[HDR_RIGHT];
        w.middle = pkt_hdr[HDR_MIDDLE];
        expected_cursors.push_back(w);
      end
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  // Offer one byte; valid stays up after acceptance unless a gap or the caller drops it
  task automatic send_byte(input logic [7:0] b);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    decode_mouse_byte(b);
  endtask

  // Well-formed packet; a nonzero dir pushes the cursor that way most of the time
  task automatic send_random_packet(input int xdir, input int ydir);
    logic [7:0] hdr;
    hdr = 8'($urandom_range(0, 255));
    hdr[HDR_SYNC] = 1'b1;
    if (xdir != 0 && $urandom_range(0, 4) != 0) hdr[HDR_XSIGN] = (xdir < 0);
    if (ydir != 0 && $urandom_range(0, 4) != 0) hdr[HDR_YSIGN] = (ydir > 0);
    send_byte(hdr);
    send_byte(8'($urandom_range(0, 255)));
    send_byte(8'($urandom_range(0, 255)));
  endtask

  // Wait for every expected word, then let the pipeline empty
  task automatic wait_drained();
    while (expected_cursors.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Rewrite all three registers while the block is idle
  task automatic apply_screen_cfg(input logic [SIZE_W-1:0] en, input logic [SIZE_W-1:0] w,
                                  input logic [SIZE_W-1:0] h);
    in_valid_i <= 1'b0;
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_DECODE_ENABLE;
    cfg_data_i  <= en;
    @(posedge clk_i);
    dec_en = en[0];
    cfg_index_i <= REG_SCREEN_WIDTH;
    cfg_data_i  <= w;
    @(posedge clk_i);
    scr_w = w;
    cfg_index_i <= REG_SCREEN_HEIGHT;
    cfg_data_i  <= h;
    @(posedge clk_i);
    scr_h = h;
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return SIZE_W'(1);
      2:       return SIZE_W'(4096);
      3:       return '1;
      4:       return SIZE_W'($urandom_range(4097, 8190));
      5:       return SIZE_W'($urandom_range(2, 64));
      default: return SIZE_W'($urandom_range(1, 4096));
    endcase
  endfunction

  // Header sync filtering, delta sign extremes, all buttons, overflow bits
  task automatic test_sync_and_extremes();
    logic [7:0] seq [0:10];
    seq = '{8'hF7, 8'h00,
            8'h08, 8'h7F, 8'h80,
            8'h3F, 8'h80, 8'h7F,
            8'hCF, 8'hFF, 8'h00};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Bytes are ignored while disabled and the packet position survives
  task automatic test_decode_disable();
    send_byte(8'h0B);
    apply_screen_cfg('0, scr_w, scr_h);
    send_byte(8'h08);
    send_byte(8'h55);
    apply_screen_cfg(SIZE_W'(1), scr_w, scr_h);
    send_byte(8'h10);
    send_byte(8'hF0);
  endtask

  // Zero size, size past the coordinate span, and a screen shrunk under the cursor
  task automatic test_screen_size_corners();
    apply_screen_cfg(SIZE_W'(1), '0, '0);
    send_byte(8'h08);
    send_byte(8'h40);
    send_byte(8'hC0);
    apply_screen_cfg(SIZE_W'(1), '1, SIZE_W'(5000));
    send_byte(8'h28);
    send_byte(8'h7F);
    send_byte(8'h80);
    apply_screen_cfg(SIZE_W'(1), SIZE_W'(16), SIZE_W'(16));
    send_byte(8'h08);
    send_byte(8'h00);
    send_byte(8'h00);
  endtask

  // Result side held off long enough for the packet queue to fill and stall input
  task automatic test_backpressure();
    apply_screen_cfg(SIZE_W'(1), SIZE_W'(4096), SIZE_W'(4096));
    tx_gaps = 1'b0;
    rx_hold_cycles = 300;
    repeat (30) send_random_packet(0, 0);
  endtask

  // Phases of random screen settings, mostly well-formed packets plus noise bytes
  task automatic test_random_traffic(input int n_items, input bit with_idle);
    int                sent;
    int                xdir;
    int                ydir;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    tx_gaps   = with_idle;
    rx_stalls = with_idle;
    sent = 0;
    while (sent < n_items) begin
      w = pick_size();
      h = pick_size();
      apply_screen_cfg(SIZE_W'(1), w, h);
      xdir = int'($urandom_range(0, 2)) - 1;
      ydir = int'($urandom_range(0, 2)) - 1;
      repeat (40) begin
        if ($urandom_range(0, 9) < 8) begin
          send_random_packet(xdir, ydir);
          sent += 3;
        end else begin
          send_byte(8'($urandom));
          sent += 1;
        end
      end
      // short stretch with decoding off, often mid-packet
      if ($urandom_range(0, 3) == 0) begin
        apply_screen_cfg('0, w, h);
        repeat (6) send_byte(8'($urandom));
      end
    end
  endtask

  // Result side ready: random stall bursts, or one long hold on request
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
        out_ready_i <= 1'b1;
      end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Compare each accepted result word with the oldest expected one
  always @(posedge clk_i) begin : check_results
    cursor_word_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_cursors.size() == 0) begin
        $error("unexpected result word: x %0d y %0d", cursor_x_o, cursor_y_o);
        err_cnt++;
      end else begin
        exp_w = expected_cursors.pop_front();
        check_field("cursor_x", exp_w.x, cursor_x_o);
        check_field("cursor_y", exp_w.y, cursor_y_o);
        check_field("button_left", exp_w.left, button_left_o);
        check_field("button_right", exp_w.right, button_right_o);
        check_field("button_middle", exp_w.middle, button_middle_o);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    in_valid_i  <= 1'b0;
    data_byte_i <= '0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= REG_DECODE_ENABLE;
    cfg_data_i  <= '0;
    rst_ni      <= 1'b0;
    err_cnt        = 0;
    tx_gaps        = 1'b0;
    rx_stalls      = 1'b0;
    rx_hold_cycles = 0;
    // tracker starts from the reset state
    dec_en  = 1'b1;
    scr_w   = WIDTH_RESET;
    scr_h   = HEIGHT_RESET;
    pkt_pos = POS_HEADER;
    pkt_hdr = '0;
    pkt_xd  = '0;
    cur_x   = '0;
    cur_y   = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_sync_and_extremes();
    test_decode_disable();
    test_screen_size_corners();
    test_backpressure();
    test_random_traffic(1000, 1'b1);
    test_random_traffic(300, 1'b0);

    in_valid_i <= 1'b0;
    wait_drained();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: ps2_mouse_packet_decoder_top.f
src/pmd_pkg.sv
src/pmd_front.sv
src/pmd_queue.sv
src/pmd_back.sv
src/ps2_mouse_packet_decoder_top.sv
tb/tb_ps2_mouse_packet_decoder_top.sv
